[design/xmodem_checksum_endpoint_defines.svh]
// Assertion macros shared by the endpoint RTL.
`ifndef XMODEM_CHECKSUM_ENDPOINT_DEFINES_SVH
`define XMODEM_CHECKSUM_ENDPOINT_DEFINES_SVH

// The antecedent holds, so the consequent must hold in the same cycle.
`define XCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// The antecedent holds, so the consequent must hold in the next cycle.
`define XCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[design/xce_pkg.sv]
package xce_pkg;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;

  localparam logic [7:0] PKT_LEN    = 8'd132;
  localparam logic [7:0] DATA_LEN   = 8'd128;
  localparam logic [7:0] CHK_POS    = 8'd131;
  localparam logic [7:0] DATA_FIRST = 8'd3;
  localparam int         BUF_AW     = 7;

  localparam logic RES_PROTO = 1'b0;
  localparam logic RES_STORE = 1'b1;

  typedef enum logic [2:0] {
    OP_MBYTE, OP_TAKEN, OP_TICK, OP_SWR, OP_SRD, OP_SETLEN
  } op_e;

  typedef enum logic [1:0] {MODE_IDLE, MODE_SEND, MODE_RECV} mode_e;

  typedef enum logic [2:0] {ST_READY, ST_RD, ST_TAKE, ST_FILL, ST_SAVE} state_e;

  typedef enum logic [1:0] {CFG_PRESENT, CFG_WRITABLE, CFG_PERIOD} cfg_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  byte_value;
    logic [16:0] address;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] result_byte;
  } out_item_t;

endpackage

[design/xce_stream_if.sv]
interface xce_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/xce_ram.sv]
module xce_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/xmodem_checksum_endpoint.sv]
// XMODEM endpoint with a plain additive checksum and 128-byte blocks, in front
// of an image store of IMAGE_BYTES bytes. Each input word is one event: a byte
// from the machine, a byte-taken notice, a keepalive tick, or a store write,
// read or length update; it yields at most one output word. A store read or
// a data byte sent from the block buffer waits in ST_RD or ST_TAKE for the
// registered memory read. Starting a send block copies 128 bytes from the
// store into the block buffer, and a good received packet is copied from the
// block buffer into the store; either copy runs through the single read port
// of the source memory at one byte per cycle. One word is worked on at a
// time, and the output register lets a new word enter while the previous
// result is being taken.
`include "xmodem_checksum_endpoint_defines.svh"

module xmodem_checksum_endpoint import xce_pkg::*; #(
  parameter int IMAGE_BYTES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  xce_stream_if.sink        in_i,
  xce_stream_if.source      out_o
);

  localparam int AW = $clog2(IMAGE_BYTES);
  localparam int LW = $clog2(IMAGE_BYTES + 1);
  localparam int SW = (LW > 23) ? LW + 1 : 24;
  localparam logic [SW-1:0] IMG = SW'(IMAGE_BYTES);

  state_e      st_q, st_d;
  mode_e       mode_q, mode_d;
  logic [15:0] blk_q, blk_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [LW-1:0] len_q, len_d;
  logic [7:0]  ka_q, ka_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [SW-1:0] raddr_q, raddr_d;
  logic        fok_q, fok_d;
  logic        present_q, present_d;
  logic        writable_q, writable_d;
  logic [7:0]  period_q, period_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [7:0]  hdr0_q, hdr0_d, hdr1_q, hdr1_d, hdr2_q, hdr2_d;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata, st_rdata;
  logic              bf_we;
  logic [BUF_AW-1:0] bf_waddr, bf_raddr;
  logic [7:0]        bf_wdata, bf_rdata;

  in_item_t      item;
  logic          acc;
  logic [SW-1:0] addr_x, len_x, blk_base, fill_base, fill_addr, save_addr, blk_end;

  assign item      = in_i.data;
  assign acc       = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == ST_READY) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign addr_x    = SW'(item.address);
  assign len_x     = SW'(len_q);
  assign blk_base  = SW'({blk_q, 7'd0});
  assign fill_base = SW'({blk_q - 16'd1, 7'd0});
  assign fill_addr = fill_base + SW'(cnt_q);
  assign save_addr = blk_base + SW'(cnt_q) - SW'(1);
  assign blk_end   = blk_base + SW'(DATA_LEN);

  xce_ram #(.Width(8), .Depth(IMAGE_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  xce_ram #(.Width(8), .Depth(int'(DATA_LEN))) u_blkbuf (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (bf_wdata),
    .raddr_i (bf_raddr),
    .rdata_o (bf_rdata)
  );

  always_comb begin
    logic       res_v;
    logic       res_kind;
    logic [7:0] res_byte;
    logic       go_idle;
    logic [7:0] p;
    logic [7:0] pn;
    logic [7:0] sbase;
    logic [8:0] eff;
    logic [8:0] cnext;
    logic       good;

    st_d = st_q;  mode_d = mode_q;  blk_d = blk_q;  pos_d = pos_q;  sum_d = sum_q;
    len_d = len_q;  ka_d = ka_q;  cnt_d = cnt_q;  raddr_d = raddr_q;  fok_d = fok_q;
    present_d = present_q;  writable_d = writable_q;  period_d = period_q;
    hdr0_d = hdr0_q;  hdr1_d = hdr1_q;  hdr2_d = hdr2_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    st_we = 1'b0;  st_waddr = '0;  st_wdata = '0;  st_raddr = '0;
    bf_we = 1'b0;  bf_waddr = '0;  bf_wdata = '0;  bf_raddr = '0;
    res_v = 1'b0;  res_kind = RES_PROTO;  res_byte = '0;  go_idle = 1'b0;
    p = '0;  pn = '0;  sbase = '0;  eff = '0;  cnext = '0;  good = 1'b0;

    unique case (st_q)
      ST_READY: begin
        if (acc) begin
          case (item.operation)
            OP_MBYTE: begin
              if (present_q) begin
                unique case (mode_q)
                  MODE_IDLE: begin
                    if (item.byte_value == B_NAK) begin
                      if (len_x == '0) begin
                        go_idle = 1'b1;
                        res_v = 1'b1;  res_byte = B_NAK;
                      end else begin
                        blk_d = 16'd1;  cnt_d = '0;  st_d = ST_FILL;
                      end
                    end else if (item.byte_value == B_SOH) begin
                      mode_d = MODE_RECV;  hdr0_d = item.byte_value;
                      pos_d = 8'd1;  sum_d = '0;  blk_d = '0;
                    end
                  end
                  MODE_SEND: begin
                    if (item.byte_value != B_NAK && item.byte_value != B_ACK) begin
                      go_idle = 1'b1;
                      res_v = 1'b1;  res_byte = B_CAN;
                    end else if (item.byte_value == B_ACK) begin
                      blk_d = blk_q + 16'd1;
                      // The new block starts where the current block number points.
                      if (blk_base >= len_x) begin
                        go_idle = 1'b1;
                        res_v = 1'b1;  res_byte = B_EOT;
                      end else begin
                        cnt_d = '0;  st_d = ST_FILL;
                      end
                    end else begin
                      pos_d = 8'd1;  sum_d = '0;
                      res_v = 1'b1;  res_byte = B_SOH;
                    end
                  end
                  MODE_RECV: begin
                    p = (pos_q >= PKT_LEN) ? 8'd0 : pos_q;
                    sbase = (p == 8'd0) ? 8'd0 : sum_q;
                    sum_d = sbase;
                    if (p == 8'd0) begin
                      hdr0_d = item.byte_value;
                    end else if (p == 8'd1) begin
                      hdr1_d = item.byte_value;
                    end else if (p == 8'd2) begin
                      hdr2_d = item.byte_value;
                    end else if (p < CHK_POS) begin
                      bf_we = 1'b1;
                      bf_waddr = BUF_AW'(p - DATA_FIRST);
                      bf_wdata = item.byte_value;
                      sum_d = sbase + item.byte_value;
                    end
                    pn = p + 8'd1;
                    pos_d = pn;
                    if (pn == 8'd1 && item.byte_value == B_EOT) begin
                      go_idle = 1'b1;
                      res_v = 1'b1;  res_byte = B_ACK;
                    end else if (pn == PKT_LEN) begin
                      pos_d = '0;  sum_d = '0;
                      good = writable_q && (hdr0_q == B_SOH) && (hdr1_q == ~hdr2_q) &&
                             (item.byte_value == sbase) &&
                             (hdr1_q == 8'(blk_q + 16'd1)) && (blk_end <= IMG);
                      if (good) begin
                        cnt_d = '0;  st_d = ST_SAVE;
                      end else begin
                        res_v = 1'b1;  res_byte = B_NAK;
                      end
                    end
                  end
                  default: ;
                endcase
              end
            end
            OP_TAKEN: begin
              if (present_q && mode_q == MODE_SEND && pos_q < PKT_LEN) begin
                pos_d = pos_q + 8'd1;
                if (pos_q == 8'd0) begin
                  sum_d = '0;
                  res_v = 1'b1;  res_byte = B_SOH;
                end else if (pos_q == 8'd1) begin
                  res_v = 1'b1;  res_byte = blk_q[7:0];
                end else if (pos_q == 8'd2) begin
                  res_v = 1'b1;  res_byte = ~blk_q[7:0];
                end else if (pos_q == CHK_POS) begin
                  res_v = 1'b1;  res_byte = sum_q;
                end else begin
                  bf_raddr = BUF_AW'(pos_q - DATA_FIRST);
                  st_d = ST_TAKE;
                end
              end
            end
            OP_TICK: begin
              if (present_q && mode_q == MODE_IDLE) begin
                // A period of zero stands for 256 ticks.
                eff = (period_q == 8'd0) ? 9'd256 : {1'b0, period_q};
                cnext = {1'b0, ka_q} + 9'd1;
                if (cnext >= eff) begin
                  ka_d = '0;
                  res_v = 1'b1;  res_byte = B_NAK;
                end else begin
                  ka_d = cnext[7:0];
                end
              end
            end
            OP_SWR: begin
              if (addr_x < IMG) begin
                st_we = 1'b1;  st_waddr = addr_x[AW-1:0];  st_wdata = item.byte_value;
              end
            end
            OP_SRD: begin
              raddr_d = addr_x;  st_raddr = addr_x[AW-1:0];  st_d = ST_RD;
            end
            OP_SETLEN: begin
              len_d = (addr_x > IMG) ? IMG[LW-1:0] : addr_x[LW-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        res_v = 1'b1;  res_kind = RES_STORE;
        res_byte = (raddr_q < len_x && raddr_q < IMG) ? st_rdata : 8'd0;
        st_d = ST_READY;
      end
      ST_TAKE: begin
        res_v = 1'b1;  res_byte = bf_rdata;
        sum_d = sum_q + bf_rdata;
        st_d = ST_READY;
      end
      ST_FILL: begin
        // Read one store byte per cycle; write the previous one into the buffer.
        if (cnt_q < DATA_LEN) begin
          st_raddr = fill_addr[AW-1:0];
          fok_d = fill_addr < len_x;
        end
        if (cnt_q != 8'd0) begin
          bf_we = 1'b1;
          bf_waddr = BUF_AW'(cnt_q - 8'd1);
          bf_wdata = fok_q ? st_rdata : 8'd0;
        end
        if (cnt_q == DATA_LEN) begin
          mode_d = MODE_SEND;  pos_d = 8'd1;  sum_d = '0;
          res_v = 1'b1;  res_byte = B_SOH;
          st_d = ST_READY;
        end else begin
          cnt_d = cnt_q + 8'd1;
        end
      end
      ST_SAVE: begin
        if (cnt_q < DATA_LEN) begin
          bf_raddr = cnt_q[BUF_AW-1:0];
        end
        if (cnt_q != 8'd0) begin
          st_we = 1'b1;  st_waddr = save_addr[AW-1:0];  st_wdata = bf_rdata;
        end
        if (cnt_q == DATA_LEN) begin
          if (blk_end > len_x) begin
            len_d = blk_end[LW-1:0];
          end
          blk_d = blk_q + 16'd1;
          res_v = 1'b1;  res_byte = B_ACK;
          st_d = ST_READY;
        end else begin
          cnt_d = cnt_q + 8'd1;
        end
      end
      default: st_d = ST_READY;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESENT: begin
          if (!(cfg_wdata_i[0] && present_q)) begin
            go_idle = 1'b1;
          end
          present_d = cfg_wdata_i[0];
        end
        CFG_WRITABLE: writable_d = cfg_wdata_i[0];
        CFG_PERIOD:   period_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (go_idle) begin
      mode_d = MODE_IDLE;  blk_d = '0;  pos_d = '0;  sum_d = '0;  ka_d = '0;
    end

    if (res_v) begin
      out_valid_d = 1'b1;
      out_d.result_kind = res_kind;
      out_d.result_byte = res_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_READY;
      mode_q <= MODE_IDLE;
      blk_q <= '0;
      pos_q <= '0;
      sum_q <= '0;
      len_q <= '0;
      ka_q <= '0;
      cnt_q <= '0;
      fok_q <= 1'b0;
      present_q <= 1'b0;
      writable_q <= 1'b1;
      period_q <= 8'd2;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mode_q <= mode_d;
      blk_q <= blk_d;
      pos_q <= pos_d;
      sum_q <= sum_d;
      len_q <= len_d;
      ka_q <= ka_d;
      cnt_q <= cnt_d;
      fok_q <= fok_d;
      present_q <= present_d;
      writable_q <= writable_d;
      period_q <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    out_q <= out_d;
    hdr0_q <= hdr0_d;
    hdr1_q <= hdr1_d;
    hdr2_q <= hdr2_d;
  end

  `XCE_ASSERT_IMPL(a_pos_range, 1'b1, pos_q <= PKT_LEN, "packet position beyond packet")
  `XCE_ASSERT_IMPL(a_copy_cnt, (st_q == ST_FILL || st_q == ST_SAVE), cnt_q <= DATA_LEN,
                   "copy counter overran the block")
  `XCE_ASSERT_IMPL(a_fill_no_store_write, st_q == ST_FILL, !st_we,
                   "store written while filling the block buffer")
  `XCE_ASSERT_NEXT(a_read_goes_rd, acc && item.operation == OP_SRD, st_q == ST_RD,
                   "store read did not enter the read state")

endmodule

[dv/tb_xmodem_checksum_endpoint.sv]
`timescale 1ns / 1ps

import xce_pkg::*;

// Tracks what the endpoint must answer for every accepted word.
class xmodem_scoreboard;
  bit          present;
  bit          writable;
  logic [7:0]  period;
  mode_e       mode;
  int          blk;
  int          pos;
  int          csum;
  int          ka;
  int          len;
  logic [7:0]  pkt[132];
  logic [7:0]  store[65536];
  bit          known[65536];
  int          prefix;
  out_item_t   due[$];
  int          errors;

  function new();
    present  = 1'b0;
    writable = 1'b1;
    period   = 8'd2;
    len      = 0;
    prefix   = 0;
    errors   = 0;
    go_idle();
  endfunction

  function void go_idle();
    mode = MODE_IDLE;
    blk  = 0;
    pos  = 0;
    csum = 0;
    ka   = 0;
  endfunction

  // Keeps the length of the written prefix of the store, which is what
  // stimulus may safely expose to sends and reads.
  function void mark(int a);
    known[a] = 1'b1;
    while (prefix < 65536 && known[prefix]) prefix++;
  endfunction

  function bit load_block();
    int start;
    int sum;
    logic [7:0] b;
    start = ((blk - 1) & 16'hffff) * 128;
    if (start >= len) return 1'b0;
    sum = 0;
    for (int i = 0; i < 128; i++) begin
      b = (start + i < len) ? store[start + i] : 8'h00;
      pkt[3 + i] = b;
      sum = (sum + b) & 255;
    end
    pkt[0]   = B_SOH;
    pkt[1]   = blk[7:0];
    pkt[2]   = 8'hff - blk[7:0];
    pkt[131] = sum[7:0];
    return 1'b1;
  endfunction

  function int emit();
    int p;
    int b;
    p = pos;
    if (p == 0) csum = 0;
    if (p == 131) begin
      b = csum;
    end else begin
      b = pkt[p];
      if (p >= 3) csum = (csum + b) & 255;
    end
    pos = p + 1;
    return b;
  endfunction

  function bit commit();
    int start;
    logic [7:0] nid;
    start = blk * 128;
    nid = 8'((blk + 1) & 255);
    if (!writable) return 1'b0;
    if (pkt[0] != B_SOH) return 1'b0;
    if (pkt[1] != 8'hff - pkt[2]) return 1'b0;
    if (pkt[131] != csum[7:0]) return 1'b0;
    if (pkt[1] != nid) return 1'b0;
    if (start + 128 > 65536) return 1'b0;
    for (int i = 0; i < 128; i++) begin
      store[start + i] = pkt[3 + i];
      mark(start + i);
    end
    if (start + 128 > len) len = start + 128;
    return 1'b1;
  endfunction

  function int on_byte(logic [7:0] d);
    int p;
    if (mode == MODE_IDLE) begin
      if (d == B_NAK) begin
        blk = 1;
        if (!load_block()) begin
          go_idle();
          return B_NAK;
        end
        mode = MODE_SEND;
        pos  = 0;
        return emit();
      end
      if (d == B_SOH) begin
        mode   = MODE_RECV;
        pkt[0] = d;
        pos    = 1;
        csum   = 0;
        blk    = 0;
      end
      return -1;
    end
    if (mode == MODE_SEND) begin
      if (d != B_NAK && d != B_ACK) begin
        go_idle();
        return B_CAN;
      end
      if (d == B_ACK) begin
        blk = (blk + 1) & 16'hffff;
        if (!load_block()) begin
          go_idle();
          return B_EOT;
        end
      end
      pos = 0;
      return emit();
    end
    p = pos;
    if (p >= 132) p = 0;
    if (p == 0) csum = 0;
    pkt[p] = d;
    if (p >= 3 && p < 131) csum = (csum + d) & 255;
    p++;
    pos = p;
    if (p == 1 && d == B_EOT) begin
      go_idle();
      return B_ACK;
    end
    if (p == 132) begin
      if (commit()) begin
        blk = (blk + 1) & 16'hffff;
        p = B_ACK;
      end else begin
        p = B_NAK;
      end
      pos  = 0;
      csum = 0;
      return p;
    end
    return -1;
  endfunction

  function void note(in_item_t it);
    int b;
    int eff;
    b = -1;
    case (it.operation)
      OP_MBYTE: if (present) b = on_byte(it.byte_value);
      OP_TAKEN: if (present && mode == MODE_SEND && pos < 132) b = emit();
      OP_TICK: begin
        if (present && mode == MODE_IDLE) begin
          eff = (period == 0) ? 256 : period;
          if (ka + 1 >= eff) begin
            ka = 0;
            b  = B_NAK;
          end else begin
            ka = (ka + 1) & 255;
          end
        end
      end
      OP_SWR: begin
        if (it.address < 65536) begin
          store[it.address[15:0]] = it.byte_value;
          mark(it.address[15:0]);
        end
      end
      OP_SRD: begin
        due.push_back({RES_STORE, (it.address < len && it.address < 65536) ?
                       store[it.address[15:0]] : 8'h00});
      end
      OP_SETLEN: len = (it.address > 65536) ? 65536 : it.address;
      default: ;
    endcase
    if (b >= 0) due.push_back({RES_PROTO, 8'(b)});
  endfunction

  function void configure(cfg_e idx, logic [7:0] v);
    case (idx)
      CFG_PRESENT: begin
        if (!v[0] || !present) go_idle();
        present = v[0];
      end
      CFG_WRITABLE: writable = v[0];
      CFG_PERIOD:   period = v;
      default: ;
    endcase
  endfunction

  function void check(out_item_t got);
    out_item_t e;
    if (due.size() == 0) begin
      $display("%0t: unexpected word kind %0d byte %02h", $time, got.result_kind,
               got.result_byte);
      errors++;
      return;
    end
    e = due.pop_front();
    if (got.result_kind !== e.result_kind) begin
      $display("%0t: result_kind expected %0d actual %0d", $time, e.result_kind,
               got.result_kind);
      errors++;
    end
    if (got.result_byte !== e.result_byte) begin
      $display("%0t: result_byte expected %02h actual %02h", $time, e.result_byte,
               got.result_byte);
      errors++;
    end
  endfunction
endclass

module tb_xmodem_checksum_endpoint;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam int         ITEM_GOAL   = 1050;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  xce_stream_if #(.T(in_item_t))  in_if ();
  xce_stream_if #(.T(out_item_t)) out_if ();

  xmodem_checksum_endpoint uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  xmodem_scoreboard sb;
  int n_items;
  bit calm;
  int stall_left;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check(out_if.data);
  end

  task automatic put_word(input logic [2:0] op, input logic [7:0] bv,
                          input logic [16:0] ad);
    in_item_t it;
    int g;
    it = '{operation: op, byte_value: bv, address: ad};
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(it);
    n_items++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Waits until every answer has come back and any store copy has finished.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_e idx, input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.configure(idx, v);
  endtask

  // Brings the protocol engine back to idle before a new exchange.
  task automatic settle();
    if (sb.mode == MODE_SEND) put_word(OP_MBYTE, B_CAN, '0);
    while (sb.mode == MODE_RECV)
      put_word(OP_MBYTE, (sb.pos % 132 == 0) ? B_EOT : 8'($urandom), '0);
  endtask

  task automatic recv_session(input int npk);
    logic [7:0] pk[132];
    int sum;
    int idx;
    settle();
    for (int k = 0; k < npk; k++) begin
      pk[0] = B_SOH;
      pk[1] = 8'((sb.blk + 1) & 255);
      pk[2] = 8'hff - pk[1];
      sum = 0;
      for (int i = 3; i < 131; i++) begin
        pk[i] = 8'($urandom);
        sum = (sum + pk[i]) & 255;
      end
      pk[131] = sum[7:0];
      if ($urandom_range(0, 4) == 0) begin
        idx = $urandom_range(0, 131);
        pk[idx] = pk[idx] ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < 132; i++) put_word(OP_MBYTE, pk[i], 17'($urandom));
    end
    if (sb.mode == MODE_RECV && sb.pos == 0) put_word(OP_MBYTE, B_EOT, '0);
  endtask

  task automatic send_session();
    int r;
    int blocks;
    logic [7:0] other;
    settle();
    put_word(OP_MBYTE, B_NAK, '0);
    blocks = 0;
    while (sb.mode == MODE_SEND && blocks < 8) begin
      repeat (131) put_word(OP_TAKEN, 8'($urandom), 17'($urandom));
      if ($urandom_range(0, 5) == 0) put_word(OP_TAKEN, '0, '0);
      if ($urandom_range(0, 7) == 0) put_word(OP_TICK, '0, '0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        put_word(OP_MBYTE, B_ACK, '0);
      end else if (r < 95) begin
        put_word(OP_MBYTE, B_NAK, '0);
      end else begin
        do other = 8'($urandom); while (other == B_ACK || other == B_NAK);
        put_word(OP_MBYTE, other, '0);
      end
      blocks++;
    end
  endtask

  // Any word, except that reads and length updates never expose store
  // bytes that were never written.
  task automatic noise_word();
    logic [2:0] op;
    int a;
    op = 3'($urandom);
    a  = $urandom_range(0, 131071);
    if (op == OP_SRD && a < sb.len && a < 65536 && !sb.known[a]) a = a + 65536;
    if (op == OP_SETLEN) a = $urandom_range(0, sb.prefix);
    put_word(op, 8'($urandom), 17'(a));
  endtask

  initial begin
    int r;
    int goal;
    logic [7:0] periods[4];
    sb = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_PRESENT;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    stall_left   = 0;
    n_items      = 0;
    calm         = 1'b0;
    periods      = '{8'd1, 8'd255, 8'd0, 8'd7};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No image attached: protocol words must be ignored.
    put_word(OP_MBYTE, B_NAK, '0);
    put_word(OP_TICK, 8'hff, 17'h1ffff);
    put_word(OP_TAKEN, '0, '0);
    put_word(OP_SWR, 8'hff, 17'd65535);
    put_word(OP_SWR, 8'h5a, 17'h1ffff);
    put_word(OP_SETLEN, '0, 17'h1ffff);
    put_word(OP_SRD, '0, 17'd65535);
    put_word(OP_SRD, '0, 17'h1ffff);
    put_word(OP_SETLEN, '0, '0);
    put_word(OP_SRD, '0, 17'd65535);
    put_word(OP_UNUSED_A, 8'hff, 17'h1ffff);
    put_word(OP_UNUSED_B, 8'h00, 17'h00000);
    drain();
    cfg_write(CFG_PRESENT, 8'h01);
    cfg_write(CFG_PERIOD, 8'd1);
    put_word(OP_TICK, '0, '0);
    put_word(OP_MBYTE, B_NAK, '0);
    put_word(OP_TAKEN, '0, '0);
    put_word(OP_MBYTE, 8'h42, '0);
    recv_session(2);
    send_session();

    for (int ph = 0; ph < 4; ph++) begin
      // Every phase starts only once all answers are in.
      drain();
      if (ph == 2) cfg_write(CFG_PRESENT, 8'h00);
      cfg_write(CFG_PRESENT, 8'h01);
      cfg_write(CFG_PERIOD, periods[ph]);
      cfg_write(CFG_WRITABLE, (ph == 1) ? 8'h00 : 8'h01);
      goal = 40 + ITEM_GOAL * (ph + 1) / 4;
      while (n_items < goal) begin
        calm = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 30) begin
          recv_session($urandom_range(1, 3));
        end else if (r < 52) begin
          send_session();
        end else if (r < 62) begin
          settle();
          repeat ((periods[ph] == 0) ? 260 : $urandom_range(1, 20))
            put_word(OP_TICK, 8'($urandom), 17'($urandom));
        end else begin
          repeat ($urandom_range(1, 10)) noise_word();
        end
      end
      calm = 1'b0;
    end

    drain();
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
